@@ src/djts_pkg.sv @@
// shared constants, codes and helpers for the drive joint torque step unit
package djts_pkg;

    localparam int CFG_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_W      = 56;
    localparam int CNT_W      = 6;
    localparam int DT_STEPS   = 16;
    localparam int GAIN_STEPS = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TSTEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd6;

    localparam logic [1:0] MODE_GEAR   = 2'd0;
    localparam logic [1:0] MODE_DIFF   = 2'd1;
    localparam logic [1:0] MODE_CLUTCH = 2'd2;

    localparam logic [1:0]  RST_MODE    = MODE_GEAR;
    localparam logic        RST_ENABLE  = 1'b1;
    localparam logic [15:0] RST_RATIO   = 16'd256;
    localparam logic [30:0] RST_SPRING  = 31'd19660800;
    localparam logic [30:0] RST_DAMPING = 31'd524288;
    localparam logic [15:0] RST_TSTEP   = 16'd655;
    localparam logic [30:0] RST_LIMIT   = 31'd65536000;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/drive_joint_torque_step_unit.sv @@
// drive joint torque step unit: bit-serial divider and multiplier sequencer
// gear and differential ticks run these steps from transfer in to result valid:
// 56 divider steps, 16 + 31 + 31 multiplier steps, 56 divider steps, then loading the output
// clutch, disabled and no-joint ticks go straight to loading the output; one tick is in work
// at a time, so a new transfer in is taken only once the last result is in the output register
// synchronous active-low reset restores register defaults and clears angle and speed state
module drive_joint_torque_step_unit
    import djts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_in_speed,
    input  logic signed [31:0]   s_out_speed,
    input  logic signed [31:0]   s_out2_speed,
    input  logic [15:0]          s_pedal,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_applied,
    output logic signed [31:0]   m_input_torque,
    output logic signed [31:0]   m_output_torque,
    output logic signed [31:0]   m_output2_torque
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV1, ST_MDT, ST_MSP, ST_MDP, ST_DIV2, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         mode_reg;
    logic               enable_reg;
    logic [15:0]        ratio_reg;
    logic [30:0]        spring_reg;
    logic [30:0]        damping_reg;
    logic [15:0]        tstep_reg;
    logic [30:0]        limit_reg;
    logic signed [31:0] angle_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] in_tgt_reg;
    logic               diff_reg;
    logic [DIV_W-1:0]   div_q_reg;
    logic [15:0]        div_rem_reg;
    logic [15:0]        div_den_reg;
    logic               div_neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] mul_a_reg;
    logic [30:0]        mul_b_reg;
    logic               res_applied_reg;
    logic signed [31:0] res_tin_reg;
    logic signed [31:0] res_to1_reg;
    logic signed [31:0] res_to2_reg;
    logic               m_valid_reg;
    logic               m_applied_reg;
    logic signed [31:0] m_tin_reg;
    logic signed [31:0] m_to1_reg;
    logic signed [31:0] m_to2_reg;

    logic               accept;
    logic [16:0]        rem_sh;
    logic               rem_ge;
    logic [15:0]        rem_next;
    logic [DIV_W-1:0]   q_next;
    logic signed [63:0] mul_sum;
    logic signed [32:0] in_ext;
    logic [32:0]        in_mag;
    logic signed [32:0] tgt_sum;
    logic signed [32:0] tgt;
    logic signed [57:0] q_signed;
    logic signed [57:0] speed_wide;
    logic signed [31:0] new_speed;
    logic signed [32:0] speed_pair;
    logic signed [63:0] delta;
    logic signed [31:0] new_angle;
    logic signed [63:0] torque;
    logic signed [63:0] torque_half;
    logic [63:0]        torque_mag;
    logic signed [32:0] clutch_d;
    logic signed [32:0] clutch_lim;
    logic signed [32:0] clutch_c;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // restoring divider step, one quotient bit per cycle
    assign rem_sh   = {div_rem_reg, div_q_reg[DIV_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, div_den_reg});
    assign rem_next = rem_ge ? 16'(rem_sh - {1'b0, div_den_reg}) : rem_sh[15:0];
    assign q_next   = {div_q_reg[DIV_W-2:0], rem_ge};

    // shift-add multiplier step, one multiplier bit per cycle
    assign mul_sum = acc_reg + (mul_b_reg[0] ? mul_a_reg : 64'sd0);

    assign in_ext = 33'(s_in_speed);
    assign in_mag = in_ext[32] ? 33'(-in_ext) : in_ext;

    assign tgt_sum    = 33'(s_out_speed) + 33'(s_out2_speed);
    assign tgt        = (tgt_sum + (tgt_sum[32] ? 33'sd1 : 33'sd0)) >>> 1;

    assign q_signed   = div_neg_reg ? -$signed({2'b00, q_next}) : $signed({2'b00, q_next});
    assign speed_wide = q_signed - 58'(in_tgt_reg);
    assign new_speed  = sat32(64'(speed_wide));
    assign speed_pair = 33'(speed_reg) + 33'(new_speed);

    assign delta     = (mul_sum + (mul_sum[63] ? 64'sd131071 : 64'sd0)) >>> 17;
    assign new_angle = sat32(64'(angle_reg) + delta);

    assign torque      = (mul_sum + (mul_sum[63] ? 64'sd65535 : 64'sd0)) >>> 16;
    assign torque_half = (torque + (torque[63] ? 64'sd1 : 64'sd0)) >>> 1;
    assign torque_mag  = torque[63] ? 64'(-torque) : 64'(torque);

    assign clutch_d   = 33'(s_in_speed) - 33'(s_out_speed);
    assign clutch_lim = $signed({2'b00, limit_reg});
    assign clutch_c   = (clutch_d > clutch_lim) ? clutch_lim :
                        (clutch_d < -clutch_lim) ? -clutch_lim : clutch_d;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= RST_MODE;
            enable_reg  <= RST_ENABLE;
            ratio_reg   <= RST_RATIO;
            spring_reg  <= RST_SPRING;
            damping_reg <= RST_DAMPING;
            tstep_reg   <= RST_TSTEP;
            limit_reg   <= RST_LIMIT;
            angle_reg   <= '0;
            speed_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:    mode_reg    <= cfg_wdata[1:0];
                    REG_ENABLE:  enable_reg  <= cfg_wdata[0];
                    REG_RATIO:   ratio_reg   <= cfg_wdata[15:0];
                    REG_SPRING:  spring_reg  <= cfg_wdata[30:0];
                    REG_DAMPING: damping_reg <= cfg_wdata[30:0];
                    REG_TSTEP:   tstep_reg   <= cfg_wdata[15:0];
                    REG_LIMIT:   limit_reg   <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_applied_reg <= 1'b0;
                        res_tin_reg     <= '0;
                        res_to1_reg     <= '0;
                        res_to2_reg     <= '0;
                        state_reg       <= ST_DONE;
                        if (mode_reg == MODE_GEAR || mode_reg == MODE_DIFF) begin
                            if (enable_reg) begin
                                diff_reg    <= (mode_reg == MODE_DIFF);
                                in_tgt_reg  <= (mode_reg == MODE_DIFF) ? tgt[31:0] : s_out_speed;
                                div_q_reg   <= DIV_W'({in_mag[31:0], 8'd0});
                                div_neg_reg <= in_ext[32];
                                div_rem_reg <= '0;
                                div_den_reg <= (ratio_reg == 16'd0) ? 16'd1 : ratio_reg;
                                cnt_reg     <= '0;
                                state_reg   <= ST_DIV1;
                            end else begin
                                angle_reg <= '0;
                            end
                        end else if (mode_reg == MODE_CLUTCH && enable_reg) begin
                            res_applied_reg <= 1'b1;
                            if (s_pedal == 16'd0) begin
                                res_to1_reg <= clutch_c[31:0];
                                res_tin_reg <= 32'(-clutch_c);
                            end
                        end
                    end
                end
                ST_DIV1: begin
                    div_q_reg   <= q_next;
                    div_rem_reg <= rem_next;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                        speed_reg <= new_speed;
                        mul_a_reg <= 64'(speed_pair);
                        mul_b_reg <= 31'(tstep_reg);
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_MDT;
                    end
                end
                ST_MDT, ST_MSP, ST_MDP: begin
                    acc_reg   <= mul_sum;
                    mul_a_reg <= mul_a_reg <<< 1;
                    mul_b_reg <= mul_b_reg >> 1;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (state_reg == ST_MDT && cnt_reg == CNT_W'(DT_STEPS - 1)) begin
                        angle_reg <= new_angle;
                        mul_a_reg <= 64'(new_angle);
                        mul_b_reg <= spring_reg;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_MSP;
                    end else if (state_reg == ST_MSP && cnt_reg == CNT_W'(GAIN_STEPS - 1)) begin
                        mul_a_reg <= 64'(speed_reg);
                        mul_b_reg <= damping_reg;
                        cnt_reg   <= '0;
                        state_reg <= ST_MDP;
                    end else if (state_reg == ST_MDP && cnt_reg == CNT_W'(GAIN_STEPS - 1)) begin
                        res_applied_reg <= 1'b1;
                        res_to1_reg     <= sat32(diff_reg ? torque_half : torque);
                        res_to2_reg     <= diff_reg ? sat32(torque_half) : 32'sd0;
                        div_q_reg       <= DIV_W'({torque_mag[46:0], 8'd0});
                        div_neg_reg     <= torque[63];
                        div_rem_reg     <= '0;
                        cnt_reg         <= '0;
                        state_reg       <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    div_q_reg   <= q_next;
                    div_rem_reg <= rem_next;
                    cnt_reg     <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                        // reaction torque is the negated quotient
                        res_tin_reg <= sat32(64'(-q_signed));
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_applied_reg <= res_applied_reg;
                        m_tin_reg     <= res_tin_reg;
                        m_to1_reg     <= res_to1_reg;
                        m_to2_reg     <= res_to2_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_applied        = m_applied_reg;
    assign m_input_torque   = m_tin_reg;
    assign m_output_torque  = m_to1_reg;
    assign m_output2_torque = m_to2_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("transfer in left the sequencer idle");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> div_rem_reg < div_den_reg)
        else $error("divider remainder not below divisor");
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_applied_reg) |->
        (m_tin_reg == 32'sd0 && m_to1_reg == 32'sd0 && m_to2_reg == 32'sd0))
        else $error("torque given without applied flag");
    a_second_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_to2_reg != 32'sd0) |-> m_to2_reg == m_to1_reg)
        else $error("second output torque differs from first");
`endif

endmodule
